>>> rtl/least_loaded_slot_assigner_unit_assert.svh
// Assertion macros used by the slot assigner checker.
`ifndef LEAST_LOADED_SLOT_ASSIGNER_UNIT_ASSERT_SVH
`define LEAST_LOADED_SLOT_ASSIGNER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LLSA_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("slot assigner check failed");

// next-cycle implication
`define LLSA_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("slot assigner check failed");

`endif

>>> rtl/llsa_pkg.sv
// Shared types and constants of the least-loaded slot assigner.
package llsa_pkg;

    localparam int SLOT_W     = 6;
    localparam int SLOTS      = 1 << SLOT_W;
    localparam int LIM_W      = SLOT_W + 1;
    localparam int COUNT_BITS = 16;
    localparam int TOTAL_W    = 16;
    localparam int MASK_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LIM_VAL_W  = 7;

    localparam logic [LIM_W-1:0] SLOTS_LIM = LIM_W'(SLOTS);

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [TOTAL_W-1:0]    total_t;

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_RENAME = 2'd1;
    localparam logic [1:0] KIND_EXIT   = 2'd2;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_ASSIGN  = 3'd1;
    localparam logic [2:0] ACT_MOVE    = 3'd2;
    localparam logic [2:0] ACT_KEEP    = 3'd3;
    localparam logic [2:0] ACT_RELEASE = 3'd4;
    localparam logic [2:0] ACT_UNPIN   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;

    // count store access, one read and one write port
    typedef struct packed {
        logic   rd_en;
        slot_t  rd_addr;
        logic   wr_en;
        slot_t  wr_addr;
        count_t wr_data;
    } cnt_req_t;

    typedef struct packed {
        logic [2:0] action;
        slot_t      slot;
        total_t     total;
        logic       error;
    } result_t;

    typedef struct packed {
        logic [MASK_W-1:0]    online_mask;
        logic [LIM_VAL_W-1:0] slots_in_use;
    } cfg_t;

endpackage

>>> rtl/llsa_count_ram.sv
// Per-slot task count memory with registered read and reset-cleared valid bits.
module llsa_count_ram (
    input  logic                clk,
    input  logic                rst_n,
    input  llsa_pkg::cnt_req_t  req,
    output llsa_pkg::count_t    rdata
);
    import llsa_pkg::*;

    count_t             mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg;
    count_t             rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            // never-written entries read as zero
            rdata_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/llsa_ctrl.sv
// Event sequencer: prior-slot lookup, least-loaded scan and count updates.
module llsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_accept,
    output logic                in_ready,
    input  logic [1:0]          in_kind,
    input  logic                in_match,
    input  logic                in_placed,
    input  llsa_pkg::slot_t     in_prior,
    input  llsa_pkg::cfg_t      cfg,
    output llsa_pkg::cnt_req_t  cnt_req,
    input  llsa_pkg::count_t    cnt_rdata,
    output llsa_pkg::result_t   res,
    output logic                res_valid,
    input  logic                res_ready
);
    import llsa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_PRIOR_RD  = 9'b000000010,
        S_PRIOR_CHK = 9'b000000100,
        S_SCAN      = 9'b000001000,
        S_PICK      = 9'b000010000,
        S_DEC       = 9'b000100000,
        S_INC_RD    = 9'b001000000,
        S_INC_WR    = 9'b010000000,
        S_OUT       = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic               placed_reg, placed_next;
    slot_t              prior_reg, prior_next;
    count_t             prior_cnt_reg, prior_cnt_next;
    logic [LIM_W-1:0]   issue_reg, issue_next;
    logic               pend_reg, pend_next;
    slot_t              pend_idx_reg, pend_idx_next;
    slot_t              best_reg, best_next;
    count_t             best_cnt_reg, best_cnt_next;
    logic               found_reg, found_next;
    logic [2:0]         action_reg, action_next;
    slot_t              slot_reg, slot_next;
    logic               err_reg, err_next;
    total_t             total_reg, total_next;

    logic [LIM_W-1:0]   lim;
    logic               issue_go;
    slot_t              pick;
    logic               is_create, is_rename, is_exit, placed_eff;

    assign lim = (LIM_W'(cfg.slots_in_use) > SLOTS_LIM) ? SLOTS_LIM
                                                         : LIM_W'(cfg.slots_in_use);
    assign issue_go   = (issue_reg < lim);
    assign pick       = found_reg ? best_reg : '0;
    assign is_create  = (in_kind == KIND_CREATE);
    assign is_rename  = (in_kind == KIND_RENAME);
    assign is_exit    = (in_kind == KIND_EXIT);
    assign placed_eff = in_placed && !is_create;

    always_comb
    begin
        state_next     = state_reg;
        placed_next    = placed_reg;
        prior_next     = prior_reg;
        prior_cnt_next = prior_cnt_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        best_next      = best_reg;
        best_cnt_next  = best_cnt_reg;
        found_next     = found_reg;
        action_next    = action_reg;
        slot_next      = slot_reg;
        err_next       = err_reg;
        total_next     = total_reg;
        cnt_req        = '0;
        res_valid      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    placed_next = placed_eff;
                    prior_next  = in_prior;
                    slot_next   = '0;
                    err_next    = 1'b0;
                    issue_next  = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    if (in_match && (is_create || (is_rename && !placed_eff)))
                    begin
                        action_next = ACT_ASSIGN;
                        state_next  = S_SCAN;
                    end
                    else if (in_match && is_rename)
                    begin
                        action_next = ACT_KEEP;
                        state_next  = S_PRIOR_RD;
                    end
                    else if (is_rename && placed_eff)
                    begin
                        action_next = ACT_UNPIN;
                        state_next  = S_PRIOR_RD;
                    end
                    else if (is_exit && in_match && placed_eff)
                    begin
                        action_next = ACT_RELEASE;
                        state_next  = S_PRIOR_RD;
                    end
                    else
                    begin
                        action_next = ACT_NONE;
                        state_next  = S_OUT;
                    end
                end
            end

            S_PRIOR_RD:
            begin
                cnt_req.rd_en   = 1'b1;
                cnt_req.rd_addr = prior_reg;
                state_next      = S_PRIOR_CHK;
            end

            S_PRIOR_CHK:
            begin
                prior_cnt_next = cnt_rdata;
                slot_next      = prior_reg;
                if (action_reg == ACT_KEEP)
                begin
                    // alone on its slot: stays put without a scan
                    if (cnt_rdata == count_t'(1))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    state_next = S_DEC;
                end
            end

            S_SCAN:
            begin
                // read issued one cycle, compared the next
                if (issue_go)
                begin
                    cnt_req.rd_en   = 1'b1;
                    cnt_req.rd_addr = issue_reg[SLOT_W-1:0];
                    issue_next      = issue_reg + LIM_W'(1);
                end
                pend_next     = issue_go;
                pend_idx_next = issue_reg[SLOT_W-1:0];
                if (pend_reg && cfg.online_mask[pend_idx_reg]
                    && (!found_reg || (cnt_rdata < best_cnt_reg)))
                begin
                    best_next     = pend_idx_reg;
                    best_cnt_next = cnt_rdata;
                    found_next    = 1'b1;
                end
                if (!issue_go && !pend_reg)
                begin
                    state_next = S_PICK;
                end
            end

            S_PICK:
            begin
                slot_next = pick;
                err_next  = err_reg | !found_reg;
                if (!placed_reg)
                begin
                    action_next = ACT_ASSIGN;
                    if (total_reg != '1)
                    begin
                        total_next = total_reg + total_t'(1);
                    end
                    state_next = S_INC_RD;
                end
                else if (pick == prior_reg)
                begin
                    action_next = ACT_KEEP;
                    state_next  = S_OUT;
                end
                else
                begin
                    action_next = ACT_MOVE;
                    state_next  = S_DEC;
                end
            end

            S_DEC:
            begin
                if (prior_cnt_reg != '0)
                begin
                    cnt_req.wr_en   = 1'b1;
                    cnt_req.wr_addr = prior_reg;
                    cnt_req.wr_data = prior_cnt_reg - count_t'(1);
                end
                else
                begin
                    err_next = 1'b1;
                end
                if (action_reg == ACT_MOVE)
                begin
                    state_next = S_INC_RD;
                end
                else
                begin
                    if (total_reg != '0)
                    begin
                        total_next = total_reg - total_t'(1);
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                    state_next = S_OUT;
                end
            end

            S_INC_RD:
            begin
                cnt_req.rd_en   = 1'b1;
                cnt_req.rd_addr = slot_reg;
                state_next      = S_INC_WR;
            end

            S_INC_WR:
            begin
                // count saturates silently
                if (cnt_rdata != '1)
                begin
                    cnt_req.wr_en   = 1'b1;
                    cnt_req.wr_addr = slot_reg;
                    cnt_req.wr_data = cnt_rdata + count_t'(1);
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        placed_reg    <= placed_next;
        prior_reg     <= prior_next;
        prior_cnt_reg <= prior_cnt_next;
        issue_reg     <= issue_next;
        pend_idx_reg  <= pend_idx_next;
        best_reg      <= best_next;
        best_cnt_reg  <= best_cnt_next;
        found_reg     <= found_next;
        action_reg    <= action_next;
        slot_reg      <= slot_next;
        err_reg       <= err_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res.action = action_reg;
    assign res.slot   = slot_reg;
    assign res.total  = total_reg;
    assign res.error  = err_reg;

endmodule

>>> rtl/least_loaded_slot_assigner_unit.sv
// Top level: config registers, output register, sequencer and count memory.
// Events, with L = min(slots_in_use, 64): one that does nothing goes straight to the output,
// a keep on a slot held alone skips the search, unpin and release read and decrement the
// prior slot's count, and assign, a keep found by the search and a move scan L slots.
// One event at a time: s_tready returns as the result enters the output register. Reset
// clears all counts (valid bits) and the total, and leaves all 64 slots online and scanned.
module least_loaded_slot_assigner_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] name_matches, [1] task_placed, [7:2] prior_slot
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] slot, [21:6] placed_total, [22] error, [23] zero
    output logic [2:0]  m_tuser,   // [2:0] action
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [llsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [llsa_pkg::MASK_W-1:0]    cfg_data
);
    import llsa_pkg::*;

    cfg_t       cfg_reg;
    cnt_req_t   cnt_req;
    count_t     cnt_rdata;
    result_t    res;
    logic       res_valid;
    logic       res_ready;
    logic       in_ready;
    logic       m_tvalid_reg;
    result_t    out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.online_mask  <= '1;
            cfg_reg.slots_in_use <= LIM_VAL_W'(SLOTS);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ONLINE_MASK:  cfg_reg.online_mask  <= cfg_data;
                CFG_SLOTS_IN_USE: cfg_reg.slots_in_use <= cfg_data[LIM_VAL_W-1:0];
                default:          ;
            endcase
        end
    end

    llsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (s_tvalid && in_ready),
        .in_ready  (in_ready),
        .in_kind   (s_tuser),
        .in_match  (s_tdata[0]),
        .in_placed (s_tdata[1]),
        .in_prior  (s_tdata[7:2]),
        .cfg       (cfg_reg),
        .cnt_req   (cnt_req),
        .cnt_rdata (cnt_rdata),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    llsa_count_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cnt_req),
        .rdata (cnt_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.action;
    assign m_tdata  = {1'b0, out_reg.error, out_reg.total, out_reg.slot};

endmodule

>>> rtl/llsa_checker.sv
// Port-level checker for the slot assigner, bound to the top level.
`include "least_loaded_slot_assigner_unit_assert.svh"

module llsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import llsa_pkg::*;

    // only defined action codes leave the block
    `LLSA_ASSERT_IMP(a_action_code, m_tvalid, m_tuser <= ACT_UNPIN)

    // an event with no effect reports slot zero and no error
    `LLSA_ASSERT_IMP(a_none_clean, m_tvalid && (m_tuser == ACT_NONE), (m_tdata[5:0] == '0) && !m_tdata[22])

    // one event at a time: input closes right after a beat is taken
    `LLSA_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // stalled result holds
    `LLSA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind least_loaded_slot_assigner_unit llsa_checker u_llsa_checker (.*);
